// ===== design/smf_pkg.sv =====
`timescale 1ns / 1ps

package smf_pkg;

    // Fixed field widths
    localparam int SAMPLE_WIDTH   = 24;
    localparam int HALF_BITS      = 4;
    localparam int KEY_WIDTH      = SAMPLE_WIDTH + 1;

    // Defaults
    localparam int              MAX_HALF_DEF = 15;
    localparam logic [HALF_BITS-1:0] HALF_RESET = 4'd1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last_sample;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] median;
        logic                           last_result;
    } t_out;

    // Control broadcast to every sort cell
    typedef struct packed {
        logic load;
        logic step;
        logic phase;
    } t_sort_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

endpackage

// ===== design/smf_sort_cell.sv =====
`timescale 1ns / 1ps

module smf_sort_cell import smf_pkg::*; #(
    parameter bit HasLeft  = 1'b1,
    parameter bit HasRight = 1'b1,
    parameter bit OddPos   = 1'b0
) (
    input  logic                 i_clk,
    input  t_sort_ctrl           i_ctrl,
    input  logic [KEY_WIDTH-1:0] i_load_key,
    input  logic [KEY_WIDTH-1:0] i_left_key,
    input  logic [KEY_WIDTH-1:0] i_right_key,
    output logic [KEY_WIDTH-1:0] o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 w_pair_right;
    logic                 w_pair_left;

    assign w_pair_right = HasRight && (OddPos == i_ctrl.phase);
    assign w_pair_left  = HasLeft  && (OddPos != i_ctrl.phase);

    // Compare-exchange: lower cell keeps the min, upper cell the max
    always_comb begin
        n_key = r_key;
        if (i_ctrl.load) begin
            n_key = i_load_key;
        end else if (i_ctrl.step) begin
            if (w_pair_right) begin
                n_key = (i_right_key < r_key) ? i_right_key : r_key;
            end else if (w_pair_left) begin
                n_key = (i_left_key > r_key) ? i_left_key : r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// ===== design/smf_sort_chain.sv =====
`timescale 1ns / 1ps

module smf_sort_chain import smf_pkg::*; #(
    parameter int WIN_LEN = 2 * MAX_HALF_DEF + 1
) (
    input  logic                           i_clk,
    input  t_sort_ctrl                     i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_win [WIN_LEN],
    input  logic [$clog2(WIN_LEN+1)-1:0]   i_n,
    input  logic [HALF_BITS-1:0]           i_h,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);

    localparam int CntW = $clog2(WIN_LEN + 1);
    localparam int IdxW = $clog2(WIN_LEN);

    logic [KEY_WIDTH-1:0] w_load [WIN_LEN];
    logic [KEY_WIDTH-1:0] w_key  [WIN_LEN];
    logic [KEY_WIDTH-1:0] w_left [WIN_LEN];
    logic [KEY_WIDTH-1:0] w_right[WIN_LEN];
    logic [KEY_WIDTH-1:0] w_sel;

    genvar j;
    generate
        for (j = 0; j < WIN_LEN; j++) begin : g_cell
            // Unsigned sort key: pad flag on top, sign bit flipped below it
            assign w_load[j] = {(CntW'(j) >= i_n), ~i_win[j][SAMPLE_WIDTH-1],
                                i_win[j][SAMPLE_WIDTH-2:0]};

            if (j > 0) begin : g_l
                assign w_left[j] = w_key[j-1];
            end else begin : g_l0
                assign w_left[j] = '0;
            end

            if (j < WIN_LEN - 1) begin : g_r
                assign w_right[j] = w_key[j+1];
            end else begin : g_r0
                assign w_right[j] = '0;
            end

            smf_sort_cell #(
                .HasLeft  (j > 0),
                .HasRight (j < WIN_LEN - 1),
                .OddPos   (j % 2 == 1)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (i_ctrl),
                .i_load_key  (w_load[j]),
                .i_left_key  (w_left[j]),
                .i_right_key (w_right[j]),
                .o_key       (w_key[j])
            );
        end
    endgenerate

    // Middle rank of the sorted window sits in cell h
    assign w_sel    = w_key[IdxW'(i_h)];
    assign o_median = {~w_sel[SAMPLE_WIDTH-1], w_sel[SAMPLE_WIDTH-2:0]};

endmodule

// ===== design/sliding_median_filter.sv =====
`timescale 1ns / 1ps

// Running median over a zero-padded, centered window of 2*h+1 samples.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one sample per request;
// last_sample closes the sequence and flushes the pending results with zeros.
// Output channel (o_out_valid / i_out_ready / o_out_data): one median per
// request; last_result marks the final result of a sequence.
// Config: i_cfg_we writes half_width (h); values above MAX_HALF act as MAX_HALF.
// Write it only while no results are pending.
//
// Each median comes from a row of sort cells doing odd-even transposition:
// load, 2*h+1 exchange rounds, emit. After a request that yields a median,
// the input is not ready until that median is valid, and is ready again in
// that cycle unless flush results follow; a request that yields none, and is
// not the last, leaves it ready. The last sample brings up to h flush
// results, with a zero-padding step first when it yields no median of its own.
//
// Reset (synchronous, active low) zeroes the window and sample count and sets
// h to 1. The result sits in an output register; if the receiver stalls, the
// block holds in its emit step until the register frees, and the held result
// stays stable on the port.

module sliding_median_filter import smf_pkg::*; #(
    parameter int MAX_HALF = MAX_HALF_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [HALF_BITS-1:0] i_cfg_data
);

    localparam int WinLen = 2 * MAX_HALF + 1;
    localparam int CntW   = $clog2(WinLen + 1);

    t_state r_state, n_state;

    logic [HALF_BITS-1:0]           r_half;
    logic signed [SAMPLE_WIDTH-1:0] r_win [WinLen];
    logic signed [SAMPLE_WIDTH-1:0] n_win [WinLen];
    logic [CntW-1:0]                r_seen, n_seen;
    logic                           r_last, n_last;
    logic [HALF_BITS-1:0]           r_flush, n_flush;
    logic [CntW-1:0]                r_round, n_round;
    logic                           r_out_valid, n_out_valid;
    t_out                           r_out, n_out;

    logic [HALF_BITS-1:0]           w_h;
    logic [CntW-1:0]                w_n;
    logic [CntW-1:0]                w_seen_inc;
    logic [HALF_BITS-1:0]           w_remain;
    logic signed [SAMPLE_WIDTH-1:0] w_median;
    t_sort_ctrl                     w_ctrl;

    // Clamp the half width to what the cell row can hold
    assign w_h = (32'(r_half) > MAX_HALF) ? HALF_BITS'(MAX_HALF) : r_half;
    assign w_n = CntW'({w_h, 1'b1});

    assign w_seen_inc = (32'(r_seen) < WinLen) ? r_seen + CntW'(1) : r_seen;
    assign w_remain   = (32'(w_seen_inc) < 32'(w_h)) ? HALF_BITS'(w_seen_inc) : w_h;

    smf_sort_chain #(
        .WIN_LEN (WinLen)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_win    (r_win),
        .i_n      (w_n),
        .i_h      (w_h),
        .o_median (w_median)
    );

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_seen      = r_seen;
        n_last      = r_last;
        n_flush     = r_flush;
        n_round     = r_round;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_ctrl      = '{load: 1'b0, step: 1'b0, phase: r_round[0]};
        o_in_ready  = 1'b0;

        // Drop the held result once the receiver takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_win[0] = i_in_data.sample;
                    for (int k = 1; k < WinLen; k++) begin
                        n_win[k] = r_win[k-1];
                    end
                    n_seen  = w_seen_inc;
                    n_last  = i_in_data.last_sample;
                    n_flush = i_in_data.last_sample ? w_remain : '0;
                    if (32'(w_seen_inc) > 32'(w_h)) begin
                        n_state = ST_LOAD;
                    end else if (i_in_data.last_sample) begin
                        n_state = ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                // Advance the window with right-hand padding
                n_win[0] = '0;
                for (int k = 1; k < WinLen; k++) begin
                    n_win[k] = r_win[k-1];
                end
                n_flush = r_flush - HALF_BITS'(1);
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                w_ctrl.load = 1'b1;
                n_round     = '0;
                n_state     = ST_SORT;
            end
            ST_SORT: begin
                w_ctrl.step = 1'b1;
                n_round     = r_round + CntW'(1);
                if (r_round == w_n - CntW'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.median      = w_median;
                    n_out.last_result = r_last && (r_flush == '0);
                    if (r_flush != '0) begin
                        n_win[0] = '0;
                        for (int k = 1; k < WinLen; k++) begin
                            n_win[k] = r_win[k-1];
                        end
                        n_flush = r_flush - HALF_BITS'(1);
                        n_state = ST_LOAD;
                    end else begin
                        if (r_last) begin
                            // Sequence done: back to the reset window
                            for (int k = 0; k < WinLen; k++) begin
                                n_win[k] = '0;
                            end
                            n_seen = '0;
                            n_last = 1'b0;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HALF_RESET;
            r_seen      <= '0;
            r_last      <= 1'b0;
            r_flush     <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WinLen; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_data;
            end
            r_seen      <= n_seen;
            r_last      <= n_last;
            r_flush     <= n_flush;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
            r_win       <= n_win;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import smf_pkg::*;

    localparam int WIN_LEN     = 2 * MAX_HALF_DEF + 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 10;
    localparam int TAIL        = 100;

    // One queued request: the sample, the idle cycles to leave after it,
    // and whether to hold it back until all pending medians are out.
    typedef struct {
        t_in data;
        int  gap_after;
        bit  drain;
    } t_sample_req;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out_data;
    logic                 i_cfg_we;
    logic [HALF_BITS-1:0] i_cfg_data;

    sliding_median_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the filter state, kept in step with accepted requests
    logic signed [SAMPLE_WIDTH-1:0] win [WIN_LEN];
    int                             seen_cnt;
    int                             half_cur;

    t_sample_req sample_q [$];
    t_out        median_q [$];

    int  err_cnt;
    int  cycle_cnt;
    int  idle_left;
    int  stall_left;
    bit  out_stall_on;
    bit  in_gaps_on;
    bit  in_busy;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic void shift_in(input logic signed [SAMPLE_WIDTH-1:0] s);
        for (int k = WIN_LEN - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = s;
    endfunction

    // Element of rank h among the 2h+1 newest samples
    function automatic logic signed [SAMPLE_WIDTH-1:0] window_median(input int h);
        int n;
        int lt;
        int le;
        n = 2 * h + 1;
        for (int i = 0; i < n; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < n; j++) begin
                if (win[j] < win[i]) lt++;
                if (win[j] <= win[i]) le++;
            end
            if (lt <= h && le > h) return win[i];
        end
        return win[0];
    endfunction

    // Advance the shadow window by one request and queue the medians it yields
    function automatic void push_medians(input t_in d);
        int   h;
        int   rem;
        t_out r;
        h = half_cur;
        shift_in(d.sample);
        if (seen_cnt < WIN_LEN) seen_cnt++;
        if (seen_cnt > h) begin
            r.median      = window_median(h);
            r.last_result = d.last_sample && (h == 0);
            median_q.push_back(r);
        end
        if (d.last_sample) begin
            // flush: pad with zeros on the right, one median per pad
            rem = (seen_cnt < h) ? seen_cnt : h;
            for (int i = 0; i < rem; i++) begin
                shift_in('0);
                r.median      = window_median(h);
                r.last_result = (i == rem - 1);
                median_q.push_back(r);
            end
            for (int k = 0; k < WIN_LEN; k++) win[k] = '0;
            seen_cnt = 0;
        end
    endfunction

    function automatic int rand_gap();
        int r;
        if (!in_gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            v = $urandom;
        end else if (r < 8) begin
            v = $urandom_range(0, 8) - 4;  // narrow range: plenty of ties
        end else if (r == 8) begin
            v = ($urandom_range(0, 1) != 0) ? 32'h007F_FFFF : 32'h0080_0000;
        end else begin
            v = 0;
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    task automatic queue_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input bit last,
                                input int gap, input bit drain);
        t_sample_req req;
        req.data.sample      = s;
        req.data.last_sample = last;
        req.gap_after        = gap;
        req.drain            = drain;
        sample_q.push_back(req);
    endtask

    // Let every queued request go out and every median come back, then settle
    task automatic wait_idle();
        while (sample_q.size() != 0 || in_busy || median_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_half(input int h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= h[HALF_BITS-1:0];
        half_cur    = (h > MAX_HALF_DEF) ? MAX_HALF_DEF : h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Sender: present queued requests, hold each until accepted
    always @(posedge i_clk) begin
        logic        nxt_valid;
        t_in         nxt_data;
        t_sample_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            idle_left  <= 0;
            in_busy     = 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_data  = i_in_data;
            if (i_in_valid && o_in_ready) begin
                push_medians(i_in_data);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && sample_q.size() != 0) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                end else if (!sample_q[0].drain || median_q.size() == 0) begin
                    req       = sample_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data  = req.data;
                    idle_left <= req.gap_after;
                end
            end
            in_busy     = nxt_valid;
            i_in_valid <= nxt_valid;
            i_in_data  <= nxt_data;
        end
    end

    // Receiver: stall at random, check each accepted median against the oldest one due
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (median_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected median %0d last %0b",
                                              o_out_data.median, o_out_data.last_result));
                end else begin
                    want = median_q.pop_front();
                    if (o_out_data.median !== want.median)
                        report_mismatch($sformatf("median got %0d want %0d",
                                                  o_out_data.median, want.median));
                    if (o_out_data.last_result !== want.last_result)
                        report_mismatch($sformatf("last_result got %0b want %0b",
                                                  o_out_data.last_result, want.last_result));
                end
            end
            if (!out_stall_on) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int rand_cnt;
        int h;
        int nseq;
        int len;
        bit open_end;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        idle_left    = 0;
        stall_left   = 0;
        out_stall_on = 1'b0;
        in_gaps_on   = 1'b0;
        in_busy      = 1'b0;
        seen_cnt     = 0;
        half_cur     = HALF_RESET;
        for (int k = 0; k < WIN_LEN; k++) win[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset half width: extremes of the sample range, back to back
        queue_sample(24'sh7F_FFFF, 1'b0, 0, 1'b0);
        queue_sample(24'sh80_0000, 1'b0, 0, 1'b0);
        queue_sample(24'sh00_0000, 1'b0, 0, 1'b0);
        queue_sample(-24'sd1,      1'b0, 0, 1'b0);
        queue_sample(24'sd1,       1'b1, 0, 1'b1);
        wait_idle();

        // Zero half width: median is the sample itself, single-sample sequence
        write_half(0);
        queue_sample(24'sh80_0000, 1'b1, 0, 1'b0);
        queue_sample(24'sd7,       1'b0, 0, 1'b0);
        queue_sample(-24'sd3,      1'b1, 0, 1'b0);
        wait_idle();

        // Widest window with a short sequence: nothing until the flush
        write_half(15);
        queue_sample(24'sd100,  1'b0, 0, 1'b0);
        queue_sample(-24'sd200, 1'b0, 0, 1'b0);
        queue_sample(24'sd300,  1'b1, 0, 1'b0);
        wait_idle();

        // Change the half width in the middle of a sequence
        write_half(2);
        queue_sample(24'sd10,  1'b0, 0, 1'b0);
        queue_sample(-24'sd10, 1'b0, 0, 1'b0);
        queue_sample(24'sd10,  1'b0, 0, 1'b0);
        queue_sample(24'sd20,  1'b0, 0, 1'b0);
        queue_sample(24'sd30,  1'b0, 0, 1'b0);
        wait_idle();
        write_half(4);
        queue_sample(-24'sd5,      1'b0, 0, 1'b0);
        queue_sample(24'sd40,      1'b0, 0, 1'b0);
        queue_sample(24'sh7F_FFFF, 1'b1, 0, 1'b0);
        wait_idle();

        // Random phases: new half width each phase, some sequences left open
        // so the next setting applies to samples already held
        rand_cnt = 0;
        while (rand_cnt < 150) begin
            case ($urandom_range(0, 5))
                0:       h = 0;
                1:       h = 15;
                2:       h = $urandom_range(0, 15);
                default: h = $urandom_range(1, 6);
            endcase
            write_half(h);
            out_stall_on = ($urandom_range(0, 3) != 0);
            in_gaps_on   = ($urandom_range(0, 3) != 0);
            nseq = $urandom_range(1, 3);
            for (int s = 0; s < nseq; s++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
                open_end = (s == nseq - 1) && ($urandom_range(0, 4) == 0);
                for (int k = 0; k < len; k++) begin
                    queue_sample(rand_sample(), (k == len - 1) && !open_end, rand_gap(),
                                 $urandom_range(0, 29) == 0);
                    rand_cnt++;
                end
            end
            wait_idle();
        end

        // Close any open sequence so its flush is checked as well
        queue_sample(rand_sample(), 1'b1, 0, 1'b0);
        while (sample_q.size() != 0 || in_busy || median_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        while (median_q.size() != 0) begin
            t_out left;
            left = median_q.pop_front();
            report_mismatch($sformatf("missing median %0d last %0b",
                                      left.median, left.last_result));
        end
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
